// ----- src/rtpfu_pkg.sv -----
package rtpfu_pkg;

    // field widths
    localparam int DATA_W        = 8;
    localparam int UNIT_LENGTH_W = 18;
    localparam int LIMIT_W       = 11;
    localparam int KIND_W        = 7;
    localparam int STAMP_W       = 32;
    localparam int SOURCE_W      = 32;
    localparam int SEQ_W         = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;

    localparam int MAX_UNIT_BYTES_DEF = 131072;
    localparam int QUEUE_DEPTH        = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLICE_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_KIND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STAMP_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ID    = 3'd4;

    // reset values
    localparam logic [LIMIT_W-1:0]  RESET_LIMIT  = 11'd1400;
    localparam logic [KIND_W-1:0]   RESET_KIND   = 7'd96;
    localparam logic [STAMP_W-1:0]  RESET_STEP   = 32'd3600;
    localparam logic [SOURCE_W-1:0] RESET_SOURCE = 32'd0;

    // RTP / FU-A constants
    localparam logic [DATA_W-1:0] VERSION_BYTE = 8'h80;
    localparam logic [DATA_W-1:0] FU_A_TYPE    = 8'd28;
    localparam logic [DATA_W-1:0] NRI_MASK     = 8'hE0;
    localparam logic [DATA_W-1:0] TYPE_MASK    = 8'h1F;
    localparam logic [DATA_W-1:0] FU_START_BIT = 8'h80;
    localparam logic [DATA_W-1:0] FU_END_BIT   = 8'h40;

    typedef struct packed {
        logic [DATA_W-1:0]        data_byte;
        logic                     unit_first;
        logic [UNIT_LENGTH_W-1:0] unit_length;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_byte;
        logic              packet_last;
        logic              run_last;
    } out_word_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  single_limit;
        logic [LIMIT_W-1:0]  slice_limit;
        logic [KIND_W-1:0]   payload_kind;
        logic [STAMP_W-1:0]  stamp_step;
        logic [SOURCE_W-1:0] source_id;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,   // nothing to send
        CMD_BYTE = 2'd1,   // payload byte only
        CMD_HDR  = 2'd2,   // RTP header, then payload byte
        CMD_FU   = 2'd3    // RTP header, FU indicator, FU header, payload byte
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [DATA_W-1:0]  data_byte;
        logic               packet_last;
        logic               marker;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
        logic [DATA_W-1:0]  fu_ind;
        logic [DATA_W-1:0]  fu_hdr;
    } cmd_t;

endpackage

// ----- src/rtpfu_front.sv -----
module rtpfu_front #(
    parameter int MAX_UNIT_BYTES = rtpfu_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rtpfu_pkg::in_word_t in_word,
    input  rtpfu_pkg::cfg_t    cfg,
    input  logic               q_full,
    output logic               push,
    output rtpfu_pkg::cmd_t    push_word
);

    localparam int REM_W = $clog2(MAX_UNIT_BYTES);
    localparam int LEN_W = $clog2(MAX_UNIT_BYTES + 1);
    localparam int CW    = (LEN_W > rtpfu_pkg::UNIT_LENGTH_W) ? LEN_W
                                                               : rtpfu_pkg::UNIT_LENGTH_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_UNIT_BYTES);

    logic [rtpfu_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [rtpfu_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [rtpfu_pkg::LIMIT_W-1:0] frag_rem_reg, frag_rem_next;
    logic [rtpfu_pkg::DATA_W-1:0]  hdr_reg, hdr_next;
    logic                          frag_reg, frag_next;
    logic                          first_frag_reg, first_frag_next;

    logic                          accept;
    logic [CW-1:0]                 len_raw, len_cl;
    logic                          frag_new;
    logic [rtpfu_pkg::STAMP_W-1:0] stamp_sum;
    logic [rtpfu_pkg::LIMIT_W-1:0] lim, take, frag_rem_dec;
    logic [REM_W-1:0]              lim_ext, take_ext;
    logic                          new_frag, frag_end;
    rtpfu_pkg::cmd_t               cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // length clean-up: zero taken as one, overlong saturated
    assign len_raw   = CW'(in_word.unit_length);
    assign len_cl    = (len_raw == '0) ? CW'(1) :
                       ((len_raw > MAX_LEN) ? MAX_LEN : len_raw);
    assign frag_new  = len_cl > CW'(cfg.single_limit);
    assign stamp_sum = stamp_reg + cfg.stamp_step;

    assign lim          = (cfg.slice_limit == '0) ? rtpfu_pkg::LIMIT_W'(1) : cfg.slice_limit;
    assign lim_ext      = REM_W'(lim);
    assign take_ext     = (rem_reg < lim_ext) ? rem_reg : lim_ext;
    assign take         = take_ext[rtpfu_pkg::LIMIT_W-1:0];
    assign frag_end     = rem_reg <= lim_ext;
    assign new_frag     = frag_rem_reg == '0;
    assign frag_rem_dec = (new_frag ? take : frag_rem_reg) - rtpfu_pkg::LIMIT_W'(1);

    always_comb
    begin
        seq_next        = seq_reg;
        stamp_next      = stamp_reg;
        rem_next        = rem_reg;
        frag_rem_next   = frag_rem_reg;
        hdr_next        = hdr_reg;
        frag_next       = frag_reg;
        first_frag_next = first_frag_reg;

        cmd.kind        = rtpfu_pkg::CMD_NONE;
        cmd.data_byte   = in_word.data_byte;
        cmd.packet_last = 1'b0;
        cmd.marker      = 1'b0;
        cmd.seq         = seq_reg;
        cmd.stamp       = in_word.unit_first ? stamp_sum : stamp_reg;
        cmd.fu_ind      = (hdr_reg & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE;
        cmd.fu_hdr      = (hdr_reg & rtpfu_pkg::TYPE_MASK)
                        | (first_frag_reg ? rtpfu_pkg::FU_START_BIT :
                           (frag_end ? rtpfu_pkg::FU_END_BIT : '0));

        if (in_word.unit_first)
        begin
            stamp_next    = stamp_sum;
            rem_next      = REM_W'(len_cl - CW'(1));
            frag_next     = frag_new;
            frag_rem_next = '0;
            if (!frag_new)
            begin
                cmd.kind        = rtpfu_pkg::CMD_HDR;
                cmd.marker      = 1'b1;
                cmd.packet_last = len_cl == CW'(1);
                seq_next        = seq_reg + 1'b1;
            end
            else
            begin
                hdr_next        = in_word.data_byte;
                first_frag_next = 1'b1;
            end
        end
        else if (rem_reg != '0)
        begin
            rem_next = rem_reg - 1'b1;
            if (!frag_reg)
            begin
                cmd.kind        = rtpfu_pkg::CMD_BYTE;
                cmd.packet_last = rem_reg == REM_W'(1);
            end
            else
            begin
                cmd.kind = rtpfu_pkg::CMD_BYTE;
                if (new_frag)
                begin
                    cmd.kind        = rtpfu_pkg::CMD_FU;
                    seq_next        = seq_reg + 1'b1;
                    first_frag_next = 1'b0;
                end
                frag_rem_next   = frag_rem_dec;
                cmd.packet_last = frag_rem_dec == '0;
            end
        end
    end

    assign push      = accept && (cmd.kind != rtpfu_pkg::CMD_NONE);
    assign push_word = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            stamp_reg      <= '0;
            rem_reg        <= '0;
            frag_rem_reg   <= '0;
            hdr_reg        <= '0;
            frag_reg       <= 1'b0;
            first_frag_reg <= 1'b1;
        end
        else if (accept)
        begin
            seq_reg        <= seq_next;
            stamp_reg      <= stamp_next;
            rem_reg        <= rem_next;
            frag_rem_reg   <= frag_rem_next;
            hdr_reg        <= hdr_next;
            frag_reg       <= frag_next;
            first_frag_reg <= first_frag_next;
        end
    end

endmodule

// ----- src/rtpfu_queue.sv -----
module rtpfu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rtpfu_pkg::cmd_t push_word,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rtpfu_pkg::cmd_t head_word
);

    localparam int DEPTH = rtpfu_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtpfu_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_word  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/rtpfu_back.sv -----
module rtpfu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  rtpfu_pkg::cmd_t      head_word,
    output logic                 pop,
    input  rtpfu_pkg::cfg_t      cfg,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rtpfu_pkg::out_word_t out_word
);

    // byte positions within one command
    localparam logic [3:0] POS_VERSION  = 4'd0;
    localparam logic [3:0] POS_KIND     = 4'd1;
    localparam logic [3:0] POS_SEQ_HI   = 4'd2;
    localparam logic [3:0] POS_SEQ_LO   = 4'd3;
    localparam logic [3:0] POS_STAMP_3  = 4'd4;
    localparam logic [3:0] POS_STAMP_2  = 4'd5;
    localparam logic [3:0] POS_STAMP_1  = 4'd6;
    localparam logic [3:0] POS_STAMP_0  = 4'd7;
    localparam logic [3:0] POS_SOURCE_3 = 4'd8;
    localparam logic [3:0] POS_SOURCE_2 = 4'd9;
    localparam logic [3:0] POS_SOURCE_1 = 4'd10;
    localparam logic [3:0] POS_SOURCE_0 = 4'd11;
    localparam logic [3:0] POS_FU_IND   = 4'd12;
    localparam logic [3:0] POS_FU_HDR   = 4'd13;
    localparam logic [3:0] POS_DATA     = 4'd14;

    logic [3:0]           idx_reg, idx_next;
    logic [3:0]           pos;
    logic                 load;
    logic [7:0]           sel_byte;
    logic                 out_valid_reg;
    rtpfu_pkg::out_word_t out_word_reg, out_word_next;

    assign pos  = (head_word.kind == rtpfu_pkg::CMD_BYTE) ? POS_DATA : idx_reg;
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && (pos == POS_DATA);

    always_comb
    begin
        unique case (pos)
            POS_VERSION:  sel_byte = rtpfu_pkg::VERSION_BYTE;
            POS_KIND:     sel_byte = {head_word.marker, cfg.payload_kind};
            POS_SEQ_HI:   sel_byte = head_word.seq[15:8];
            POS_SEQ_LO:   sel_byte = head_word.seq[7:0];
            POS_STAMP_3:  sel_byte = head_word.stamp[31:24];
            POS_STAMP_2:  sel_byte = head_word.stamp[23:16];
            POS_STAMP_1:  sel_byte = head_word.stamp[15:8];
            POS_STAMP_0:  sel_byte = head_word.stamp[7:0];
            POS_SOURCE_3: sel_byte = cfg.source_id[31:24];
            POS_SOURCE_2: sel_byte = cfg.source_id[23:16];
            POS_SOURCE_1: sel_byte = cfg.source_id[15:8];
            POS_SOURCE_0: sel_byte = cfg.source_id[7:0];
            POS_FU_IND:   sel_byte = head_word.fu_ind;
            POS_FU_HDR:   sel_byte = head_word.fu_hdr;
            POS_DATA:     sel_byte = head_word.data_byte;
            default:      sel_byte = '0;
        endcase
    end

    always_comb
    begin
        out_word_next.out_byte    = sel_byte;
        out_word_next.packet_last = (pos == POS_DATA) && head_word.packet_last;
        out_word_next.run_last    = pos == POS_DATA;

        // single packets skip the FU bytes
        if (pos == POS_DATA)
            idx_next = POS_VERSION;
        else if ((pos == POS_SOURCE_0) && (head_word.kind == rtpfu_pkg::CMD_HDR))
            idx_next = POS_DATA;
        else
            idx_next = pos + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= POS_VERSION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- src/rtp_h264_fu_a_packetizer_core.sv -----
// RTP packetiser for H.264 NAL units with FU-A fragmentation. NAL bytes come in one word
// per byte, header byte first, with the unit length on the first word (unit_first = 1).
// Each unit steps the timestamp by stamp_step before use. Units of up to single_limit
// bytes go out as one packet (12-byte RTP header, marker set, then the unit). Longer units
// lose their header byte and are cut into FU-A fragments of at most slice_limit payload
// bytes (zero as one), each with a 12-byte header (marker clear), FU indicator and FU
// header. Output is one packet byte per word, packet_last on the final byte of a packet,
// run_last on the last byte caused by an input word. Rate: the back end emits one byte
// per cycle unless stalled; a plain payload byte yields one output byte, a single
// packet's first byte 13 and a fragment's first byte 15; the front end takes one word per
// cycle while the 4-entry command queue has room, so header bursts are absorbed and
// payload streams at one byte per cycle. A fragmented unit's header byte yields no
// output. Configuration registers are written through cfg_write / cfg_index / cfg_data
// and must only be changed while the block is idle; writes to unused indexes are ignored.
module rtp_h264_fu_a_packetizer_core #(
    parameter int MAX_UNIT_BYTES = rtpfu_pkg::MAX_UNIT_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rtpfu_pkg::in_word_t                 in_word,
    // output words
    output logic                                out_valid,
    input  logic                                out_stall,
    output rtpfu_pkg::out_word_t                out_word,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [rtpfu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rtpfu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rtpfu_pkg::cfg_t cfg_reg;
    rtpfu_pkg::cmd_t push_word;
    rtpfu_pkg::cmd_t head_word;
    logic            push;
    logic            q_full;
    logic            pop;
    logic            head_valid;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.single_limit <= rtpfu_pkg::RESET_LIMIT;
            cfg_reg.slice_limit  <= rtpfu_pkg::RESET_LIMIT;
            cfg_reg.payload_kind <= rtpfu_pkg::RESET_KIND;
            cfg_reg.stamp_step   <= rtpfu_pkg::RESET_STEP;
            cfg_reg.source_id    <= rtpfu_pkg::RESET_SOURCE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rtpfu_pkg::CFG_SINGLE_LIMIT:
                    cfg_reg.single_limit <= cfg_data[rtpfu_pkg::LIMIT_W-1:0];
                rtpfu_pkg::CFG_SLICE_LIMIT:
                    cfg_reg.slice_limit  <= cfg_data[rtpfu_pkg::LIMIT_W-1:0];
                rtpfu_pkg::CFG_PAYLOAD_KIND:
                    cfg_reg.payload_kind <= cfg_data[rtpfu_pkg::KIND_W-1:0];
                rtpfu_pkg::CFG_STAMP_STEP:
                    cfg_reg.stamp_step   <= cfg_data[rtpfu_pkg::STAMP_W-1:0];
                rtpfu_pkg::CFG_SOURCE_ID:
                    cfg_reg.source_id    <= cfg_data[rtpfu_pkg::SOURCE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: unit tracking, sequence / timestamp, fragment decisions
    rtpfu_front #(
        .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    // short command queue decoupling front from serialiser
    rtpfu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // back: header / FU byte serialiser with registered output
    rtpfu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

// ----- test/rtp_h264_fu_a_packetizer_core_test.sv -----
module rtp_h264_fu_a_packetizer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // register index that maps to nothing; a write there must change nothing
    localparam logic [rtpfu_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    localparam int MAX_UNIT      = rtpfu_pkg::MAX_UNIT_BYTES_DEF;
    localparam int SETTLE_CYCLES = 64;    // command queue of 4, up to 15 bytes each
    localparam int LONG_HOLD     = 400;   // receiver hold-off used to back the block up
    localparam int STUCK_LIMIT   = 4000;  // cycles with work pending and nothing moving

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    rtpfu_pkg::in_word_t  in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    rtpfu_pkg::out_word_t out_word;

    logic                              cfg_write = 1'b0;
    logic [rtpfu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rtpfu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    rtp_h264_fu_a_packetizer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shared state between stimulus, driver, receiver and monitor
    // ------------------------------------------------------------------
    rtpfu_pkg::in_word_t  nal_words_todo[$];   // words waiting to be offered
    rtpfu_pkg::out_word_t packet_bytes_due[$]; // packet bytes predicted, oldest first

    bit tx_calm = 1'b0;             // sender offers back to back
    bit rx_calm = 1'b0;             // receiver never stalls
    int hold_ticket = 0;            // bumped to request one long receiver hold-off

    int errors = 0;
    int words_queued = 0;
    int words_taken = 0;
    int bytes_checked = 0;
    int single_pkts = 0;
    int fu_pkts = 0;
    int abandoned_units = 0;
    int stray_bytes = 0;

    // ------------------------------------------------------------------
    // Packetiser prediction: our own copy of registers and state
    // ------------------------------------------------------------------
    logic [rtpfu_pkg::LIMIT_W-1:0]  single_lim;
    logic [rtpfu_pkg::LIMIT_W-1:0]  slice_lim;
    logic [rtpfu_pkg::KIND_W-1:0]   pay_kind;
    logic [rtpfu_pkg::STAMP_W-1:0]  stamp_inc;
    logic [rtpfu_pkg::SOURCE_W-1:0] ssrc;

    logic [rtpfu_pkg::SEQ_W-1:0]   seq_no = '0;
    logic [rtpfu_pkg::STAMP_W-1:0] stamp = '0;
    logic [16:0]                   unit_left = '0;
    logic [rtpfu_pkg::LIMIT_W-1:0] frag_left = '0;
    logic [rtpfu_pkg::DATA_W-1:0]  nal_hdr = '0;
    logic                          in_fu = 1'b0;
    logic                          first_frag = 1'b1;

    initial
    begin
        single_lim = rtpfu_pkg::RESET_LIMIT;
        slice_lim  = rtpfu_pkg::RESET_LIMIT;
        pay_kind   = rtpfu_pkg::RESET_KIND;
        stamp_inc  = rtpfu_pkg::RESET_STEP;
        ssrc       = rtpfu_pkg::RESET_SOURCE;
    end

    function automatic void due_byte(input logic [rtpfu_pkg::DATA_W-1:0] b,
                                     input logic last);
        rtpfu_pkg::out_word_t w;
        w.out_byte    = b;
        w.packet_last = last;
        w.run_last    = 1'b0;
        packet_bytes_due.push_back(w);
    endfunction

    // 12-byte RTP header; the sequence number moves on per packet
    function automatic void due_rtp_header(input logic marker);
        due_byte(rtpfu_pkg::VERSION_BYTE, 1'b0);
        due_byte({marker, pay_kind}, 1'b0);
        due_byte(seq_no[15:8], 1'b0);
        due_byte(seq_no[7:0], 1'b0);
        due_byte(stamp[31:24], 1'b0);
        due_byte(stamp[23:16], 1'b0);
        due_byte(stamp[15:8], 1'b0);
        due_byte(stamp[7:0], 1'b0);
        due_byte(ssrc[31:24], 1'b0);
        due_byte(ssrc[23:16], 1'b0);
        due_byte(ssrc[15:8], 1'b0);
        due_byte(ssrc[7:0], 1'b0);
        seq_no = seq_no + 1'b1;
    endfunction

    function automatic void packetise_word(input rtpfu_pkg::in_word_t w);
        int unsigned len;
        int unsigned left;
        int unsigned lim;
        int unsigned take;
        logic [rtpfu_pkg::DATA_W-1:0] fu;
        int start_size;
        rtpfu_pkg::out_word_t tail;
        start_size = packet_bytes_due.size();
        if (w.unit_first)
        begin
            if (unit_left != 0)
                abandoned_units++;
            len = w.unit_length;
            if (len == 0)
                len = 1;
            if (len > MAX_UNIT)
                len = MAX_UNIT;
            stamp      = stamp + stamp_inc;
            unit_left  = 17'(len - 1);
            in_fu      = len > single_lim;
            frag_left  = '0;
            if (!in_fu)
            begin
                due_rtp_header(1'b1);
                due_byte(w.data_byte, unit_left == 0);
                single_pkts++;
            end
            else
            begin
                // header byte held back for the FU indicator and FU header
                nal_hdr    = w.data_byte;
                first_frag = 1'b1;
            end
        end
        else if (unit_left != 0)
        begin
            left      = unit_left;
            unit_left = unit_left - 1'b1;
            if (!in_fu)
                due_byte(w.data_byte, unit_left == 0);
            else
            begin
                if (frag_left == 0)
                begin
                    lim  = (slice_lim == 0) ? 1 : slice_lim;
                    take = (left < lim) ? left : lim;
                    fu   = nal_hdr & rtpfu_pkg::TYPE_MASK;
                    if (first_frag)
                        fu = fu | rtpfu_pkg::FU_START_BIT;
                    else if (take == left)
                        fu = fu | rtpfu_pkg::FU_END_BIT;
                    due_rtp_header(1'b0);
                    due_byte((nal_hdr & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE, 1'b0);
                    due_byte(fu, 1'b0);
                    first_frag = 1'b0;
                    frag_left  = take[rtpfu_pkg::LIMIT_W-1:0];
                    fu_pkts++;
                end
                frag_left = frag_left - 1'b1;
                due_byte(w.data_byte, frag_left == 0);
            end
        end
        else
            stray_bytes++;

        if (packet_bytes_due.size() > start_size)
        begin
            tail = packet_bytes_due.pop_back();
            tail.run_last = 1'b1;
            packet_bytes_due.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers words from the queue with random gaps between them
    // ------------------------------------------------------------------
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            gap_left <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            // gap_left is the pause owed after the word just taken
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (nal_words_todo.size() != 0)
            begin
                in_word  <= nal_words_todo.pop_front();
                in_valid <= 1'b1;
                gap_left <= tx_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    int hold_seen = 0;
    int stall_left = 0;
    int rx_pick;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_seen  <= 0;
        end
        else if (hold_ticket != hold_seen)
        begin
            hold_seen  <= hold_ticket;
            stall_left <= LONG_HOLD - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (rx_calm)
            out_stall <= 1'b0;
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 65)
                out_stall <= 1'b0;
            else if (rx_pick < 93)
            begin
                stall_left <= $urandom_range(0, 2);
                out_stall  <= 1'b1;
            end
            else
            begin
                stall_left <= $urandom_range(10, 40);
                out_stall  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted input word and checks every
    // accepted output word against the oldest prediction. Prediction comes
    // first so a same-edge result could never be missed.
    // ------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin : watch
        rtpfu_pkg::out_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                packetise_word(in_word);
                words_taken++;
            end
            if (out_valid && !out_stall)
            begin
                bytes_checked++;
                if (packet_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got byte %02h last %b/%b",
                             $time, out_word.out_byte, out_word.packet_last,
                             out_word.run_last);
                    errors++;
                end
                else
                begin
                    want = packet_bytes_due.pop_front();
                    if (out_word.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.out_byte, out_word.out_byte);
                        errors++;
                    end
                    if (out_word.packet_last !== want.packet_last)
                    begin
                        $display("%0t: packet_last expected %b got %b",
                                 $time, want.packet_last, out_word.packet_last);
                        errors++;
                    end
                    if (out_word.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %b got %b",
                                 $time, want.run_last, out_word.run_last);
                        errors++;
                    end
                end
            end

            // watchdog: only counts while something is still owed
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else if (nal_words_todo.size() != 0 || in_valid || packet_bytes_due.size() != 0)
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d bytes still due",
                         $time, stuck_cycles, packet_bytes_due.size());
                $display("rtp_h264_fu_a_packetizer_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_word(input logic [rtpfu_pkg::DATA_W-1:0] b,
                                       input logic first,
                                       input logic [rtpfu_pkg::UNIT_LENGTH_W-1:0] len);
        rtpfu_pkg::in_word_t w;
        w.data_byte   = b;
        w.unit_first  = first;
        w.unit_length = len;
        nal_words_todo.push_back(w);
        words_queued++;
    endfunction

    // one unit: header word with the length field, then sent-1 body bytes
    // (sent below the length leaves the unit open for an early new unit)
    function automatic void queue_unit(input int unsigned len_field, input int unsigned sent,
                                       input logic [rtpfu_pkg::DATA_W-1:0] hdr);
        queue_word(hdr, 1'b1, len_field[rtpfu_pkg::UNIT_LENGTH_W-1:0]);
        for (int unsigned k = 1; k < sent; k++)
            queue_word(8'($urandom), 1'b0, 18'($urandom));
    endfunction

    // blocks until the block has drained and had time to go idle
    task automatic settle();
        do
            @(negedge clk);
        while (nal_words_todo.size() != 0 || in_valid || packet_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reg(input logic [rtpfu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            rtpfu_pkg::CFG_SINGLE_LIMIT: single_lim = val[rtpfu_pkg::LIMIT_W-1:0];
            rtpfu_pkg::CFG_SLICE_LIMIT:  slice_lim  = val[rtpfu_pkg::LIMIT_W-1:0];
            rtpfu_pkg::CFG_PAYLOAD_KIND: pay_kind   = val[rtpfu_pkg::KIND_W-1:0];
            rtpfu_pkg::CFG_STAMP_STEP:   stamp_inc  = val;
            rtpfu_pkg::CFG_SOURCE_ID:    ssrc       = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input int unsigned single, input int unsigned slice,
                           input int unsigned kind, input logic [31:0] step,
                           input logic [31:0] src);
        set_reg(rtpfu_pkg::CFG_SINGLE_LIMIT, single);
        set_reg(rtpfu_pkg::CFG_SLICE_LIMIT, slice);
        set_reg(rtpfu_pkg::CFG_PAYLOAD_KIND, kind);
        set_reg(rtpfu_pkg::CFG_STAMP_STEP, step);
        set_reg(rtpfu_pkg::CFG_SOURCE_ID, src);
    endtask

    // Mostly complete units with random content and small lengths so that
    // fragments are short; a share of them cut short, stray bytes between
    // units and the odd oversized length field.
    function automatic void random_units(input int target);
        int n;
        int unsigned len;
        int unsigned sent;
        int r;
        n = 0;
        while (n < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                len  = $urandom_range(MAX_UNIT + 1, (1 << rtpfu_pkg::UNIT_LENGTH_W) - 1);
                sent = $urandom_range(1, 5);
            end
            else
            begin
                len  = (r < 85) ? $urandom_range(1, 16) : $urandom_range(17, 40);
                sent = len;
                if (r >= 90 && len > 1)
                    sent = $urandom_range(1, len - 1);
            end
            queue_unit(len, sent, 8'($urandom));
            n += sent;
            if ($urandom_range(0, 99) < 8)
            begin
                queue_word(8'($urandom), 1'b0, 18'($urandom));
                n++;
            end
        end
    endfunction

    task automatic random_config();
        set_all(($urandom_range(0, 99) < 70) ? $urandom_range(0, 12) : $urandom_range(13, 1436),
                ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(0, 1434),
                $urandom_range(0, 127), $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: shortest unit, zero length taken as one, a stray
        // byte with nothing open, and a short whole unit
        queue_unit(1, 1, 8'h00);
        queue_unit(0, 1, 8'hFF);
        queue_word(8'h5A, 1'b0, 18'h2AAAA);
        queue_unit(2, 2, 8'h67);
        settle();

        // tight limits and top-end header values
        set_all(4, 3, 127, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        tx_calm = 1'b1;
        queue_unit(4, 4, 8'h65);          // exactly at the single limit
        queue_unit(8, 8, 8'hFF);          // three fragments, end bit on the last
        queue_unit(18'h3FFFF, 3, 8'h00);  // oversized length, cut off mid fragment
        queue_unit(2, 2, 8'h41);          // early new unit, sent whole
        settle();

        // zero limits: every unit fragmented, slice of one byte
        tx_calm = 1'b0;
        rx_calm = 1'b1;
        set_all(0, 0, 0, 32'd1, 32'hFFFF_FFFF);
        set_reg(CFG_SPARE_INDEX, 32'hFFFF_FFFF);
        queue_unit(1, 1, 8'h7C);          // nothing sent, timestamp still steps
        queue_unit(2, 2, 8'h41);          // single fragment: start bit only
        settle();

        // largest limits used in this test
        rx_calm = 1'b0;
        set_all(1436, 1434, 96, 32'd0, 32'd0);
        queue_unit(3, 3, 8'h06);
        settle();
        set_reg(rtpfu_pkg::CFG_SINGLE_LIMIT, 2);
        queue_unit(6, 6, 8'h1C);          // one fragment under the largest slice
        settle();

        // random phases: plain, back to back on both sides, long hold-off
        random_config();
        random_units(15);
        settle();

        random_config();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        random_units(15);
        settle();

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        set_all($urandom_range(0, 4), $urandom_range(1, 3), $urandom_range(0, 127),
                $urandom, $urandom);
        random_units(15);
        hold_ticket++;                    // receiver sits still while words keep coming
        settle();

        random_config();
        random_units(15);
        settle();

        $display("covered %0d input words, %0d packet bytes checked, %0d errors",
                 words_taken, bytes_checked, errors);
        $display("  %0d whole-unit packets, %0d FU-A fragments, %0d abandoned, %0d stray",
                 single_pkts, fu_pkts, abandoned_units, stray_bytes);
        if (errors == 0 && packet_bytes_due.size() == 0)
            $display("rtp_h264_fu_a_packetizer_core regression: pass");
        else
            $display("rtp_h264_fu_a_packetizer_core regression: fail");
        $finish;
    end

endmodule
